### rtl/matrix4_inverse_macros.svh
// assertion macros shared by the matrix inverse rtl
`ifndef MATRIX4_INVERSE_MACROS_SVH
`define MATRIX4_INVERSE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MI4_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MI4_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MI4_ASSERT(lbl, clk, rst, prop, msg)
`define MI4_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### rtl/mi4_pkg.sv
// shared types and constants of the matrix inverse block
package mi4_pkg;

   localparam int MAT_ENTRIES = 16;
   localparam int IDX_WIDTH   = 4;

   // divider start request
   typedef struct packed {
      logic start;
   } div_ctl_type;

   // divider status
   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

### rtl/mi4_divider.sv
// restoring unsigned divider, one quotient bit per cycle
module mi4_divider
   import mi4_pkg::*;
#(
   parameter int NUM_WIDTH = 67,
   parameter int DEN_WIDTH = 69,
   parameter int QUO_WIDTH = 18
) (
   input  logic                 clock,
   input  logic                 reset,
   input  div_ctl_type          ctl,
   input  logic [NUM_WIDTH-1:0] num,
   input  logic [DEN_WIDTH-1:0] den,
   output div_sts_type          sts,
   output logic [QUO_WIDTH-1:0] quo
);

   localparam int SH_WIDTH  = DEN_WIDTH + QUO_WIDTH - 1;
   localparam int XW        = (NUM_WIDTH > SH_WIDTH) ? NUM_WIDTH : SH_WIDTH;
   localparam int CNT_WIDTH = $clog2(QUO_WIDTH + 1);

   logic [XW-1:0]        rem_ff;
   logic [XW-1:0]        dsh_ff;
   logic [QUO_WIDTH-1:0] quo_ff;
   logic [CNT_WIDTH-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic                 ge;

   assign ge = rem_ff >= dsh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == CNT_WIDTH'(1))) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         rem_ff <= XW'(num);
         dsh_ff <= XW'(den) << (QUO_WIDTH - 1);
         cnt_ff <= CNT_WIDTH'(QUO_WIDTH);
      end else if (busy_ff) begin
         if (ge) begin
            rem_ff <= rem_ff - dsh_ff;
         end
         quo_ff <= {quo_ff[QUO_WIDTH-2:0], ge};
         dsh_ff <= dsh_ff >> 1;
         cnt_ff <= cnt_ff - CNT_WIDTH'(1);
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quo      = quo_ff;

endmodule

### rtl/matrix4_inverse.sv
// top level of the 4x4 fixed-point matrix inverse
// Loads sixteen signed fixed-point elements (ELEM_WIDTH bits, FRAC_BITS
// fraction bits) in row-major order, one request per cycle while req_stall
// is low. After the sixteenth element the block stalls requests and works
// from two single-port memories with registered reads: the element memory
// and the exact cofactor memory (adjugate order). Each 3x3 cofactor fetches
// its nine elements from the element memory and is then built on the
// single shared multiplier. The determinant follows (four products along
// the first row). A zero determinant gives one result flagged singular.
// Otherwise each of the sixteen quotients goes through memory read and
// setup and the bit-serial divider, then waits for a free output
// register. The output register lets the next matrix start loading while
// the last result waits.
`include "matrix4_inverse_macros.svh"

module matrix4_inverse
   import mi4_pkg::*;
#(
   parameter int ELEM_WIDTH = 16,
   parameter int FRAC_BITS  = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ELEM_WIDTH-1:0] req_elem_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ELEM_WIDTH-1:0] rsp_inv_value,
   output logic [IDX_WIDTH-1:0]  rsp_inv_index,
   output logic                  rsp_singular,
   output logic                  rsp_saturated,
   output logic                  rsp_last_result
);

   // widths that keep every intermediate exact
   localparam int W   = ELEM_WIDTH;
   localparam int PW  = 2 * W + 1;          // 2x2 determinant
   localparam int CW  = 3 * W + 3;          // cofactor
   localparam int PRW = CW + W;             // multiplier product
   localparam int DW  = CW + W + 2;         // determinant
   localparam int NW  = CW + 2 * FRAC_BITS; // scaled numerator
   localparam int QW  = W + 2;              // quotient incl. overflow bit

   localparam logic [QW-1:0] HALF = QW'(1) << (W - 1);

   // sequencer states
   localparam logic [3:0] S_LOAD  = 4'd0;
   localparam logic [3:0] S_FETCH = 4'd1;
   localparam logic [3:0] S_CALC  = 4'd2;
   localparam logic [3:0] S_CWR   = 4'd3;
   localparam logic [3:0] S_DREAD = 4'd4;
   localparam logic [3:0] S_DMUL  = 4'd5;
   localparam logic [3:0] S_DACC  = 4'd6;
   localparam logic [3:0] S_CHECK = 4'd7;
   localparam logic [3:0] S_QREAD = 4'd8;
   localparam logic [3:0] S_QSET  = 4'd9;
   localparam logic [3:0] S_QWAIT = 4'd10;
   localparam logic [3:0] S_EMIT  = 4'd11;

   logic [3:0]           state_ff, state_in;
   logic [IDX_WIDTH-1:0] load_cnt_ff;
   logic [IDX_WIDTH-1:0] mnr_ff;       // cofactor being built: {row, col}
   logic [3:0]           fetch_cnt_ff;
   logic [1:0]           fi_ff, fj_ff; // position inside the 3x3 minor
   logic [1:0]           term_ff;
   logic [2:0]           ph_ff;
   logic [1:0]           dc_ff;
   logic [IDX_WIDTH-1:0] k_ff;

   logic signed [W-1:0]  e_ff [0:8];

   // memories
   logic [W-1:0]         mat_mem [0:MAT_ENTRIES-1];
   logic [W-1:0]         mat_rd_ff;
   logic [IDX_WIDTH-1:0] mat_addr;
   logic [CW-1:0]        cof_mem [0:MAT_ENTRIES-1];
   logic [CW-1:0]        cof_rd_ff;
   logic [IDX_WIDTH-1:0] cof_addr;
   logic [CW-1:0]        cof_wdata;

   // arithmetic
   logic signed [CW-1:0]  mul_a;
   logic signed [W-1:0]   mul_b;
   logic signed [PRW-1:0] prod_ff;
   logic signed [PW-1:0]  dd_ff;
   logic signed [CW-1:0]  acc_ff;
   logic signed [DW-1:0]  det_ff;
   logic                  neg_ff;

   logic signed [W-1:0] e1x, e1y, e2x, e2y, e0t;
   logic [1:0]          frow, fcol;

   // divider hookup
   div_ctl_type   div_ctl;
   div_sts_type   div_sts;
   logic [QW-1:0] div_quo;
   logic [CW-1:0] cof_mag;
   logic [DW-1:0] det_mag;
   logic [NW-1:0] div_num;

   // finished result and output register
   logic [W-1:0]         res_value_ff;
   logic [IDX_WIDTH-1:0] res_index_ff;
   logic                 res_sing_ff, res_sat_ff, res_last_ff;
   logic                 rsp_valid_ff;
   logic [W-1:0]         rsp_value_ff;
   logic [IDX_WIDTH-1:0] rsp_index_ff;
   logic                 rsp_singular_ff, rsp_sat_ff, rsp_last_ff;

   logic                 load_go;
   logic                 emit_go;
   logic [QW-1:0]        q_clip;
   logic [QW-1:0]        q_neg;
   logic                 q_sat;

   assign req_stall = (state_ff != S_LOAD);
   assign load_go   = req_valid && !req_stall;
   assign emit_go   = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);

   // rows and columns of the minor skip the cofactor's own row and column
   assign frow = fi_ff + {1'b0, (fi_ff >= mnr_ff[3:2])};
   assign fcol = fj_ff + {1'b0, (fj_ff >= mnr_ff[1:0])};

   assign mat_addr = (state_ff == S_DREAD) ? {2'b00, dc_ff} : {frow, fcol};
   assign cof_addr = (state_ff == S_DREAD) ? {dc_ff, 2'b00} : k_ff;

   // cofactor sign follows (row + col) parity; stored transposed
   assign cof_wdata = (mnr_ff[2] ^ mnr_ff[0]) ? CW'(-acc_ff) : CW'(acc_ff);

   always_ff @(posedge clock) begin
      if (load_go) begin
         mat_mem[load_cnt_ff] <= req_elem_value;
      end
      mat_rd_ff <= mat_mem[mat_addr];
   end

   // no read of an entry overlaps its write: the sequencer writes all
   // sixteen cofactors before any read of them is issued
   always_ff @(posedge clock) begin
      if (state_ff == S_CWR) begin
         cof_mem[{mnr_ff[1:0], mnr_ff[3:2]}] <= cof_wdata;
      end
      cof_rd_ff <= cof_mem[cof_addr];
   end

   // operand pick for the three expansion terms of a 3x3 minor
   always_comb begin
      unique case (term_ff)
         2'd1: begin
            e1x = e_ff[3]; e1y = e_ff[5]; e2x = e_ff[6]; e2y = e_ff[8]; e0t = e_ff[1];
         end
         2'd2: begin
            e1x = e_ff[3]; e1y = e_ff[4]; e2x = e_ff[6]; e2y = e_ff[7]; e0t = e_ff[2];
         end
         default: begin
            e1x = e_ff[4]; e1y = e_ff[5]; e2x = e_ff[7]; e2y = e_ff[8]; e0t = e_ff[0];
         end
      endcase
   end

   // shared multiplier input select
   always_comb begin
      if (state_ff == S_DMUL) begin
         mul_a = signed'(cof_rd_ff);
         mul_b = signed'(mat_rd_ff);
      end else begin
         unique case (ph_ff)
            3'd1: begin
               mul_a = CW'(e1y);
               mul_b = e2x;
            end
            3'd3: begin
               mul_a = CW'(dd_ff);
               mul_b = e0t;
            end
            default: begin
               mul_a = CW'(e1x);
               mul_b = e2y;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // divider operands: magnitudes, numerator scaled by two fraction widths
   assign cof_mag = cof_rd_ff[CW-1] ? (CW'(0) - cof_rd_ff) : cof_rd_ff;
   assign det_mag = det_ff[DW-1] ? (DW'(0) - DW'(det_ff)) : DW'(det_ff);
   assign div_num = NW'(cof_mag) << (2 * FRAC_BITS);
   assign div_ctl.start = (state_ff == S_QSET);

   mi4_divider #(
      .NUM_WIDTH (NW),
      .DEN_WIDTH (DW),
      .QUO_WIDTH (QW)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .num   (div_num),
      .den   (det_mag),
      .sts   (div_sts),
      .quo   (div_quo)
   );

   // clip to the element range; most negative value stays unclipped
   always_comb begin
      if (neg_ff) begin
         q_sat  = div_quo > HALF;
         q_clip = q_sat ? HALF : div_quo;
      end else begin
         q_sat  = div_quo > (HALF - QW'(1));
         q_clip = q_sat ? (HALF - QW'(1)) : div_quo;
      end
      q_neg = QW'(0) - q_clip;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_LOAD:  if (load_go && (load_cnt_ff == IDX_WIDTH'(MAT_ENTRIES - 1))) begin
                     state_in = S_FETCH;
                  end
         S_FETCH: if (fetch_cnt_ff == 4'd9) begin
                     state_in = S_CALC;
                  end
         S_CALC:  if ((ph_ff == 3'd4) && (term_ff == 2'd2)) begin
                     state_in = S_CWR;
                  end
         S_CWR:   state_in = (mnr_ff == IDX_WIDTH'(MAT_ENTRIES - 1)) ? S_DREAD : S_FETCH;
         S_DREAD: state_in = S_DMUL;
         S_DMUL:  state_in = S_DACC;
         S_DACC:  state_in = (dc_ff == 2'd3) ? S_CHECK : S_DREAD;
         S_CHECK: state_in = (det_ff == '0) ? S_EMIT : S_QREAD;
         S_QREAD: state_in = S_QSET;
         S_QSET:  state_in = S_QWAIT;
         S_QWAIT: if (div_sts.done) begin
                     state_in = S_EMIT;
                  end
         S_EMIT:  if (emit_go) begin
                     state_in = res_last_ff ? S_LOAD : S_QREAD;
                  end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_LOAD;
         load_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (load_go) begin
            load_cnt_ff <= load_cnt_ff + IDX_WIDTH'(1);
         end
      end
   end

   // sequencer datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_LOAD: begin
            mnr_ff       <= '0;
            fetch_cnt_ff <= '0;
            fi_ff        <= '0;
            fj_ff        <= '0;
            acc_ff       <= '0;
         end
         S_FETCH: begin
            // read data arrives in the cycle after its address
            if (fetch_cnt_ff != 4'd0) begin
               e_ff[fetch_cnt_ff - 4'd1] <= signed'(mat_rd_ff);
            end
            if (fj_ff == 2'd2) begin
               fj_ff <= '0;
               fi_ff <= fi_ff + 2'd1;
            end else begin
               fj_ff <= fj_ff + 2'd1;
            end
            fetch_cnt_ff <= fetch_cnt_ff + 4'd1;
            term_ff      <= '0;
            ph_ff        <= '0;
         end
         S_CALC: begin
            unique case (ph_ff)
               3'd1: dd_ff <= prod_ff[PW-1:0];
               3'd2: dd_ff <= dd_ff - prod_ff[PW-1:0];
               3'd4: begin
                  if (term_ff == 2'd1) begin
                     acc_ff <= acc_ff - prod_ff[CW-1:0];
                  end else begin
                     acc_ff <= acc_ff + prod_ff[CW-1:0];
                  end
                  term_ff <= term_ff + 2'd1;
               end
               default: ;
            endcase
            ph_ff <= (ph_ff == 3'd4) ? 3'd0 : ph_ff + 3'd1;
         end
         S_CWR: begin
            mnr_ff       <= mnr_ff + IDX_WIDTH'(1);
            fetch_cnt_ff <= '0;
            fi_ff        <= '0;
            fj_ff        <= '0;
            acc_ff       <= '0;
            dc_ff        <= '0;
            det_ff       <= '0;
         end
         S_DACC: begin
            det_ff <= det_ff + DW'(prod_ff);
            dc_ff  <= dc_ff + 2'd1;
         end
         S_CHECK: begin
            k_ff         <= '0;
            res_value_ff <= '0;
            res_index_ff <= '0;
            res_sing_ff  <= 1'b1;
            res_sat_ff   <= 1'b0;
            res_last_ff  <= 1'b1;
         end
         S_QSET: begin
            neg_ff <= cof_rd_ff[CW-1] ^ det_ff[DW-1];
         end
         S_QWAIT: begin
            if (div_sts.done) begin
               res_value_ff <= neg_ff ? q_neg[W-1:0] : q_clip[W-1:0];
               res_index_ff <= k_ff;
               res_sing_ff  <= 1'b0;
               res_sat_ff   <= q_sat;
               res_last_ff  <= (k_ff == IDX_WIDTH'(MAT_ENTRIES - 1));
            end
         end
         S_EMIT: begin
            if (emit_go) begin
               k_ff <= k_ff + IDX_WIDTH'(1);
            end
         end
         default: ;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_value_ff    <= res_value_ff;
         rsp_index_ff    <= res_index_ff;
         rsp_singular_ff <= res_sing_ff;
         rsp_sat_ff      <= res_sat_ff;
         rsp_last_ff     <= res_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_inv_value   = rsp_value_ff;
   assign rsp_inv_index   = rsp_index_ff;
   assign rsp_singular    = rsp_singular_ff;
   assign rsp_saturated   = rsp_sat_ff;
   assign rsp_last_result = rsp_last_ff;

   `MI4_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == S_LOAD) && !rsp_valid_ff, "not idle after reset")
   `MI4_ASSERT(a_sing_last, clock, reset, rsp_valid_ff && rsp_singular_ff |-> rsp_last_ff && (rsp_value_ff == '0), "singular result malformed")
   `MI4_ASSERT(a_div_done, clock, reset, div_sts.done |-> (state_ff == S_QWAIT), "divider done outside wait")
   `MI4_ASSERT(a_load_wrap, clock, reset, (state_ff != S_LOAD) |-> (load_cnt_ff == '0), "load count not wrapped")

endmodule
